### rtl/core/pmd_pkg.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher package
// Shared payload types, status codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // Request kinds carried in req_type.
  localparam logic REQ_POST     = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_POSTED     = 2'd0;
  localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
  localparam logic [1:0] STATUS_IDLE       = 2'd2;
  localparam logic [1:0] STATUS_BAD_TASK   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_TASK_COUNT = 1'b0;
  localparam logic CFG_PRIO_TABLE = 1'b1;

  // Field widths fixed by the transaction format.
  localparam int TASK_W   = 4;
  localparam int HANDLE_W = 8;
  localparam int SIG_W    = 8;
  localparam int PRIO_W   = 3;
  localparam int CNT_W    = 5;
  localparam int CFG_W    = 48;
  localparam int TBL_ROWS = 16;

  // Task id bound: ids at or above it are refused, on top of the configured count.
  localparam int MAX_TASKS = 16;

  typedef logic [TBL_ROWS-1:0][PRIO_W-1:0] pmd_prio_tbl_t;

  typedef struct packed {
    logic                req_type;
    logic [TASK_W-1:0]   dest_task;
    logic [HANDLE_W-1:0] msg_handle;
    logic [SIG_W-1:0]    signal;
  } pmd_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TASK_W-1:0]   task_id;
    logic [PRIO_W-1:0]   priority_res;
    logic [HANDLE_W-1:0] out_handle;
    logic [SIG_W-1:0]    out_signal;
    logic [TASK_W-1:0]   source_task;
  } pmd_res_t;

  // Per-message record held in the message memory.
  typedef struct packed {
    logic [TASK_W-1:0] dest;
    logic [TASK_W-1:0] source;
    logic [SIG_W-1:0]  sig;
  } pmd_msg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_post;  // post accepted: update queues, load result
    logic load_none;  // dispatch accepted with nothing ready
    logic read_link;  // dispatch accepted: read head's link and record
    logic pop_head;   // link data back: advance head, load result
  } pmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_ready;
  } pmd_stat_t;

endpackage

### rtl/core/pmd_stream_if.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface pmd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/pmd_ram.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pmd_ctrl.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher controller
// Handshake control and sequencing of post and dispatch transactions.
// ----------------------------------------------------------------------------
module pmd_ctrl import pmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_req_type_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pmd_stat_t stat_i,
  output pmd_cmd_t  cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic is_dispatch;

  // A new transaction is taken when idle and the result slot is free or emptying.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    accept      = in_valid_i && in_ready_o;
    is_dispatch = (in_req_type_i == REQ_DISPATCH);

    cmd_o.load_post = accept && !is_dispatch;
    cmd_o.load_none = accept && is_dispatch && !stat_i.any_ready;
    cmd_o.read_link = accept && is_dispatch && stat_i.any_ready;
    cmd_o.pop_head  = (state_q == ST_READ);
  end

  // Next state: a dispatch with work waits in the read state for the link memory.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.read_link) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result slot occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_post || cmd_o.load_none || cmd_o.pop_head) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // The read cycle only ever follows a dispatch that found a ready queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> $past(cmd_o.read_link))
    else $error("read cycle without a started dispatch");

  // The result slot is empty while a dispatch is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("result slot occupied during dispatch read");
`endif

endmodule

### rtl/core/pmd_datapath.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher datapath
// Configuration, ready bitmap, queue pointers, link and message memories.
// ----------------------------------------------------------------------------
module pmd_datapath import pmd_pkg::*; #(
  parameter int NUM_PRIORITIES = 8,
  parameter int POOL_SIZE      = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  pmd_req_t         req_i,
  input  pmd_cmd_t         cmd_i,
  output pmd_stat_t        stat_o,
  output pmd_res_t         res_o
);

  localparam int PW = $clog2(NUM_PRIORITIES);
  localparam int HW = $clog2(POOL_SIZE);
  localparam int HANDLE_VALUES = 2 ** HANDLE_W;

  // Configuration registers.
  logic [CNT_W-1:0]      task_cnt_q;
  pmd_prio_tbl_t         prio_tbl_q;

  // Scheduler state.
  logic [NUM_PRIORITIES-1:0] ready_mask_q;
  logic [TASK_W-1:0]         current_task_q;
  logic [HW-1:0]             head_q [NUM_PRIORITIES];
  logic [HW-1:0]             tail_q [NUM_PRIORITIES];

  // Dispatch in flight.
  logic [PW-1:0] sel_pri_q;
  logic [HW-1:0] sel_h_q;
  logic          sel_last_q;

  pmd_res_t res_q;

  // Handle to pool index, reduced modulo the pool size.
  logic [HW-1:0] hmod_tab [HANDLE_VALUES];
  for (genvar g = 0; g < HANDLE_VALUES; g++) begin : g_hmod
    localparam logic [HW-1:0] HMOD = HW'(g % POOL_SIZE);
    assign hmod_tab[g] = HMOD;
  end

  logic [HW-1:0]     post_h;
  logic [PRIO_W-1:0] tbl_pri;
  logic [PW-1:0]     post_pri;
  logic              post_bad;
  logic              post_ok;
  logic [PW-1:0]     disp_pri;
  logic [HW-1:0]     disp_h;
  logic [PW-1:0]     tail_raddr;
  logic [HW-1:0]     tail_rd;
  pmd_msg_t          msg_wr;
  pmd_msg_t          msg_rd;
  logic [HW-1:0]     link_rd;
  logic              link_we;

  // Post decode: validity, priority lookup and saturation.
  always_comb begin
    post_h   = hmod_tab[req_i.msg_handle];
    post_bad = ({1'b0, req_i.dest_task} >= task_cnt_q) ||
               (32'(req_i.dest_task) >= MAX_TASKS);
    post_ok  = cmd_i.load_post && !post_bad;
    tbl_pri  = prio_tbl_q[req_i.dest_task];
    if (32'(tbl_pri) >= NUM_PRIORITIES) begin
      post_pri = PW'(NUM_PRIORITIES - 1);
    end else begin
      post_pri = PW'(tbl_pri);
    end
  end

  // Highest set ready bit wins.
  always_comb begin
    disp_pri = '0;
    for (int p = 0; p < NUM_PRIORITIES; p++) begin
      if (ready_mask_q[p]) begin
        disp_pri = PW'(p);
      end
    end
  end

  // One shared tail read port, steered by the request kind.
  always_comb begin
    tail_raddr = (req_i.req_type == REQ_DISPATCH) ? disp_pri : post_pri;
    tail_rd    = tail_q[tail_raddr];
    disp_h     = head_q[disp_pri];
    link_we    = post_ok && ready_mask_q[post_pri];
    msg_wr     = '{dest: req_i.dest_task, source: current_task_q, sig: req_i.signal};
  end

  assign stat_o.any_ready = |ready_mask_q;

  // Link memory: successor of each queued handle.
  pmd_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (tail_rd),
    .wdata_i (post_h),
    .re_i    (cmd_i.read_link),
    .raddr_i (disp_h),
    .rdata_o (link_rd)
  );

  // Message memory: destination, source and signal of each handle.
  pmd_ram #(
    .WIDTH ($bits(pmd_msg_t)),
    .DEPTH (POOL_SIZE)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (post_ok),
    .waddr_i (post_h),
    .wdata_i (msg_wr),
    .re_i    (cmd_i.read_link),
    .raddr_i (disp_h),
    .rdata_o (msg_rd)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_cnt_q <= '0;
      prio_tbl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TASK_COUNT: task_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_PRIO_TABLE: prio_tbl_q <= cfg_wdata_i;
        default:        task_cnt_q <= task_cnt_q;
      endcase
    end
  end

  // Ready bitmap and current task.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_mask_q   <= '0;
      current_task_q <= '0;
    end else begin
      if (post_ok) begin
        ready_mask_q[post_pri] <= 1'b1;
      end else if (cmd_i.pop_head) begin
        if (sel_last_q) begin
          ready_mask_q[sel_pri_q] <= 1'b0;
        end
        current_task_q <= msg_rd.dest;
      end
    end
  end

  // Queue head and tail pointers.
  always_ff @(posedge clk_i) begin
    if (post_ok) begin
      tail_q[post_pri] <= post_h;
      if (!ready_mask_q[post_pri]) begin
        head_q[post_pri] <= post_h;
      end
    end else if (cmd_i.pop_head && !sel_last_q) begin
      head_q[sel_pri_q] <= link_rd;
    end
  end

  // Capture the chosen queue while the memories are read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.read_link) begin
      sel_pri_q  <= disp_pri;
      sel_h_q    <= disp_h;
      sel_last_q <= (disp_h == tail_rd);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_post) begin
      if (post_bad) begin
        res_q <= '{status: STATUS_BAD_TASK, task_id: req_i.dest_task,
                   priority_res: '0, out_handle: '0, out_signal: '0, source_task: '0};
      end else begin
        res_q <= '{status: STATUS_POSTED, task_id: req_i.dest_task,
                   priority_res: PRIO_W'(post_pri), out_handle: HANDLE_W'(post_h),
                   out_signal: req_i.signal, source_task: current_task_q};
      end
    end else if (cmd_i.load_none) begin
      res_q <= '{status: STATUS_IDLE, task_id: '0, priority_res: '0,
                 out_handle: '0, out_signal: '0, source_task: '0};
    end else if (cmd_i.pop_head) begin
      res_q <= '{status: STATUS_DISPATCHED, task_id: msg_rd.dest,
                 priority_res: PRIO_W'(sel_pri_q), out_handle: HANDLE_W'(sel_h_q),
                 out_signal: msg_rd.sig, source_task: msg_rd.source};
    end
  end

  assign res_o = res_q;

`ifndef NO_ASSERTIONS
  // Popping the last entry of a queue leaves its ready bit clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_head && sel_last_q) |=> !ready_mask_q[$past(sel_pri_q)])
    else $error("ready bit still set after last entry popped");

  // An accepted post always leaves its priority marked ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    post_ok |=> ready_mask_q[$past(post_pri)])
    else $error("ready bit not set after post");
`endif

endmodule

### rtl/core/priority_message_dispatcher.sv
// ----------------------------------------------------------------------------
// Priority message dispatcher
// Active-object scheduler: per-priority message FIFOs with a ready bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per transaction: a post (req_type 0) queues a
//   message handle for a task at the priority taken from the configured
//   table; a dispatch (req_type 1) pops the oldest message of the highest
//   ready priority. res returns exactly one result per request.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the block is idle: index 0 is the task count, index 1 the table.
//   A post or an empty dispatch shows its result in the cycle after
//   acceptance; a dispatch with work passes through a read state, as the
//   head's link and message record come from the registered read port of
//   the link and message memories. Posts can be taken every cycle while
//   results are taken; no request is taken in the read state of a dispatch.
//   Reset clears the ready bitmap, the current task and the configuration;
//   no memory clearing pass is needed, so the block is usable at once.
//   A stalled receiver holds the result; the next request is taken as soon
//   as the result slot is being emptied.
// ----------------------------------------------------------------------------
module priority_message_dispatcher import pmd_pkg::*; #(
  parameter int NUM_PRIORITIES = 8,
  parameter int POOL_SIZE      = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  pmd_stream_if.sink       req,
  pmd_stream_if.source     res
);

  pmd_cmd_t  cmd;
  pmd_stat_t stat;
  pmd_req_t  req_payload;
  pmd_res_t  res_payload;

  assign req_payload = req.payload;
  assign res.payload = res_payload;

  // Sequencing and handshake control.
  pmd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req.valid),
    .in_req_type_i (req_payload.req_type),
    .in_ready_o    (req.ready),
    .out_valid_o   (res.valid),
    .out_ready_i   (res.ready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Queue state and memories.
  pmd_datapath #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .POOL_SIZE      (POOL_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_payload),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_payload)
  );

endmodule

### sim/tb_priority_message_dispatcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Priority message dispatcher testbench
// Drives post and dispatch requests through the request channel, predicts
// every result with a behavioural copy of the scheduler queues, and checks
// each result transaction field by field, under several configurations and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_priority_message_dispatcher;
  import pmd_pkg::*;

  localparam int NUM_PRIO       = 8;
  localparam int POOL_ENTRIES   = 256;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 235;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  pmd_stream_if #(.payload_t(pmd_req_t)) req_if ();
  pmd_stream_if #(.payload_t(pmd_res_t)) res_if ();

  priority_message_dispatcher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .res         (res_if)
  );

  // Scheduler state mirrored by the predictor.
  logic [NUM_PRIO-1:0] ready_bits;
  logic [7:0]          head_of[NUM_PRIO];
  logic [7:0]          tail_of[NUM_PRIO];
  logic [7:0]          link_mem[POOL_ENTRIES];
  logic [7:0]          sig_mem[POOL_ENTRIES];
  logic [3:0]          src_mem[POOL_ENTRIES];
  logic [3:0]          dest_mem[POOL_ENTRIES];
  logic [3:0]          cur_task;
  logic [CNT_W-1:0]    tasks_registered;
  logic [CFG_W-1:0]    prio_table;

  // Occupancy bookkeeping used to steer the stimulus.
  int                  handle_uses[POOL_ENTRIES];
  int                  messages_queued;

  pmd_res_t            awaited_results[$];
  int                  err_cnt;
  int                  quiet_cycles;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: ready is redrawn at every edge according to the stall rate.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The run is abandoned when the block stops moving.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("priority_message_dispatcher test failed");
    $finish;
  end

  // Reports one field of a result that differs from the prediction.
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name, want, got);
      err_cnt++;
    end
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    pmd_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $realtime,
                 res_if.payload);
        err_cnt++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 8'(want.status), 8'(res_if.payload.status));
        check_field("task_id", 8'(want.task_id), 8'(res_if.payload.task_id));
        check_field("priority_res", 8'(want.priority_res),
                    8'(res_if.payload.priority_res));
        check_field("out_handle", want.out_handle, res_if.payload.out_handle);
        check_field("out_signal", want.out_signal, res_if.payload.out_signal);
        check_field("source_task", 8'(want.source_task), 8'(res_if.payload.source_task));
      end
    end
  end

  // Works out the result of one request and updates the mirrored queues.
  task automatic schedule_request(input pmd_req_t rq, output pmd_res_t rs);
    logic [PRIO_W-1:0] pri;
    logic [7:0]        h;
    bit                found;
    rs    = '0;
    pri   = '0;
    found = 1'b0;
    if (rq.req_type == REQ_POST) begin
      if ({1'b0, rq.dest_task} >= tasks_registered || 32'(rq.dest_task) >= MAX_TASKS) begin
        rs.status  = STATUS_BAD_TASK;
        rs.task_id = rq.dest_task;
      end else begin
        // Three table bits always name one of the eight queues, so no
        // saturation is needed at this queue count.
        pri          = prio_table[3*rq.dest_task +: PRIO_W];
        h            = rq.msg_handle;
        sig_mem[h]   = rq.signal;
        src_mem[h]   = cur_task;
        dest_mem[h]  = rq.dest_task;
        if (ready_bits[pri]) begin
          link_mem[tail_of[pri]] = h;
        end else begin
          head_of[pri]    = h;
          ready_bits[pri] = 1'b1;
        end
        tail_of[pri] = h;
        handle_uses[h]++;
        messages_queued++;
        rs.status       = STATUS_POSTED;
        rs.task_id      = rq.dest_task;
        rs.priority_res = pri;
        rs.out_handle   = h;
        rs.out_signal   = rq.signal;
        rs.source_task  = cur_task;
      end
    end else begin
      for (int p = 0; p < NUM_PRIO; p++) begin
        if (ready_bits[p]) begin
          pri   = PRIO_W'(p);
          found = 1'b1;
        end
      end
      if (!found) begin
        rs.status = STATUS_IDLE;
      end else begin
        h = head_of[pri];
        if (h == tail_of[pri]) begin
          ready_bits[pri] = 1'b0;
        end else begin
          head_of[pri] = link_mem[h];
        end
        cur_task = dest_mem[h];
        if (handle_uses[h] > 0) handle_uses[h]--;
        messages_queued--;
        rs.status       = STATUS_DISPATCHED;
        rs.task_id      = dest_mem[h];
        rs.priority_res = pri;
        rs.out_handle   = h;
        rs.out_signal   = sig_mem[h];
        rs.source_task  = src_mem[h];
      end
    end
  endtask

  function automatic pmd_req_t make_req(input logic kind, input logic [3:0] dest,
                                        input logic [7:0] handle, input logic [7:0] sig);
    pmd_req_t rq;
    rq.req_type   = kind;
    rq.dest_task  = dest;
    rq.msg_handle = handle;
    rq.signal     = sig;
    return rq;
  endfunction

  // Sends one request transaction and records its predicted result.
  // Valid is left high on return; a drain, or an idle draw in the next call, lowers it.
  task automatic issue_request(input pmd_req_t rq);
    pmd_res_t rs;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    schedule_request(rq, rs);
    awaited_results.push_back(rs);
  endtask

  // Stops the request channel and waits for every outstanding result.
  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic set_config(input logic [CNT_W-1:0] count, input logic [CFG_W-1:0] table_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TASK_COUNT;
    cfg_wdata_i <= CFG_W'(count);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PRIO_TABLE;
    cfg_wdata_i <= table_val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tasks_registered = count;
    prio_table       = table_val;
  endtask

  // Picks a handle that is not queued at present, if one exists.
  function automatic logic [7:0] pick_free_handle();
    int start;
    start = $urandom_range(POOL_ENTRIES - 1);
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      if (handle_uses[(start + i) % POOL_ENTRIES] == 0) return 8'((start + i) % POOL_ENTRIES);
    end
    return 8'(start);
  endfunction

  // Before any configuration every post is refused and nothing is ready.
  task automatic test_unconfigured_requests();
    issue_request(make_req(REQ_DISPATCH, 4'd0, 8'd0, 8'd0));
    issue_request(make_req(REQ_POST, 4'd0, 8'd1, 8'd2));
    issue_request(make_req(REQ_POST, 4'd15, 8'd255, 8'd255));
  endtask

  // Highest priority first, oldest first within a priority, then empty.
  task automatic test_priority_ordering();
    logic [CFG_W-1:0] tbl;
    wait_for_drain();
    tbl = '0;
    for (int i = 0; i < TBL_ROWS; i++) tbl[3*i +: PRIO_W] = i[PRIO_W-1:0];
    set_config(5'd16, tbl);
    issue_request(make_req(REQ_POST, 4'd0, 8'd0, 8'd0));
    issue_request(make_req(REQ_POST, 4'd7, 8'd255, 8'd255));
    issue_request(make_req(REQ_POST, 4'd3, 8'd10, 8'h5A));
    issue_request(make_req(REQ_POST, 4'd3, 8'd11, 8'hA5));
    issue_request(make_req(REQ_POST, 4'd15, 8'd20, 8'h3C));
    repeat (6) issue_request(make_req(REQ_DISPATCH, 4'd0, 8'd0, 8'd0));
    // The last dispatched task becomes the source of the next post.
    issue_request(make_req(REQ_POST, 4'd2, 8'd30, 8'h81));
    issue_request(make_req(REQ_DISPATCH, 4'd15, 8'd255, 8'd255));
  endtask

  // The first id past the registered count is refused, the last one taken.
  task automatic test_bad_task_boundary();
    wait_for_drain();
    set_config(5'd15, prio_table);
    issue_request(make_req(REQ_POST, 4'd15, 8'd40, 8'd1));
    issue_request(make_req(REQ_POST, 4'd14, 8'd200, 8'd7));
    issue_request(make_req(REQ_DISPATCH, 4'd0, 8'd0, 8'd0));
  endtask

  // Mixed posts and dispatches; posts mostly use registered tasks and free
  // handles, the rest are refused ids, re-used handles and empty dispatches.
  task automatic run_traffic(input logic [CNT_W-1:0] count, input logic [CFG_W-1:0] table_val,
                             input int idle_mode, input int n_items);
    int         post_pct;
    logic [3:0] dest;
    logic [7:0] handle;
    wait_for_drain();
    set_config(count, table_val);
    send_idle_pct  = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 12 : 0;
    recv_stall_pct = (idle_mode == 2) ? 61 : (idle_mode == 3) ? 12 : 0;
    for (int k = 0; k < n_items; k++) begin
      post_pct = (messages_queued < 4) ? 70 : (messages_queued > 40) ? 30 : 50;
      if ($urandom_range(99) < post_pct && messages_queued < 200) begin
        if (tasks_registered != 0 && $urandom_range(99) < 85) begin
          dest = 4'($urandom_range(tasks_registered - 1));
        end else begin
          dest = 4'($urandom_range(15));
        end
        handle = ($urandom_range(99) < 2) ? 8'($urandom_range(255)) : pick_free_handle();
        issue_request(make_req(REQ_POST, dest, handle, 8'($urandom_range(255))));
      end else begin
        issue_request(make_req(REQ_DISPATCH, 4'($urandom_range(15)),
                               8'($urandom_range(255)), 8'($urandom_range(255))));
      end
    end
  endtask

  // Configurations from all-lowest to all-highest priority, with every
  // idling pattern on the two channels.
  task automatic test_random_traffic_phases();
    run_traffic(5'd16, CFG_W'({$urandom, $urandom}), 0, PHASE_ITEMS);
    run_traffic(5'd16, {CFG_W{1'b1}}, 1, PHASE_ITEMS);
    run_traffic(5'd16, '0, 2, PHASE_ITEMS);
    run_traffic(5'd5, CFG_W'({$urandom, $urandom}), 3, PHASE_ITEMS);
    run_traffic(5'd1, CFG_W'({$urandom, $urandom}), 0, PHASE_ITEMS);
    run_traffic(5'd0, CFG_W'({$urandom, $urandom}), 1, 60);
    run_traffic(5'($urandom_range(16)), CFG_W'({$urandom, $urandom}), 2, PHASE_ITEMS);
    run_traffic(5'd16, CFG_W'({$urandom, $urandom}), 3, PHASE_ITEMS);
    run_traffic(5'd9, CFG_W'({$urandom, $urandom}), 0, PHASE_ITEMS);
  endtask

  // Reset, then the tests in turn.
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_TASK_COUNT;
    cfg_wdata_i      <= '0;
    req_if.valid     <= 1'b0;
    req_if.payload   <= '0;
    ready_bits       = '0;
    cur_task         = '0;
    tasks_registered = '0;
    prio_table       = '0;
    messages_queued  = 0;
    err_cnt          = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    for (int i = 0; i < POOL_ENTRIES; i++) handle_uses[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unconfigured_requests();
    test_priority_ordering();
    test_bad_task_boundary();
    test_random_traffic_phases();
    wait_for_drain();
    if (err_cnt == 0) begin
      $display("priority_message_dispatcher test passed");
    end else begin
      $display("priority_message_dispatcher test failed");
    end
    $finish;
  end

endmodule
